/* hw/rtl/krs_pkg.sv */
// shared types and codes for the keyed record store
// no dependencies
package krs_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  localparam int unsigned SlotBits = 3;
  localparam int unsigned Slots    = 8;

  // one record header: valid, tags and which slots hold a written value
  typedef struct packed {
    logic              valid;
    logic [31:0]       key;
    logic [31:0]       ctx;
    logic [Slots-1:0]  written;
  } tag_entry_t;

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_PROBE = 5'b00100,
    ST_SLOT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

/* hw/rtl/krs_if.sv */
// request and response channel interfaces of the keyed record store
// depends on nothing but plain logic types
interface krs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [31:0]        key_tag;
  logic [31:0]        context_tag;
  logic [2:0]         slot_select;
  logic signed [31:0] write_value;

  modport source (output valid, action, key_tag, context_tag, slot_select, write_value,
                  input ready);
  modport sink   (input valid, action, key_tag, context_tag, slot_select, write_value,
                  output ready);
endinterface

interface krs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               hit;
  logic               store_full;

  modport source (output valid, read_value, hit, store_full, input ready);
  modport sink   (input valid, read_value, hit, store_full, output ready);
endinterface

/* hw/rtl/krs_tag_ram.sv */
// record header memory, one write and one registered read port
// depends on krs_pkg for the entry type
module krs_tag_ram #(
  parameter int unsigned Entries = 64,
  parameter int unsigned Aw      = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [Aw-1:0]       waddr_i,
  input  krs_pkg::tag_entry_t wdata_i,
  input  logic [Aw-1:0]       raddr_i,
  output krs_pkg::tag_entry_t rdata_o
);

  krs_pkg::tag_entry_t mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/krs_slot_ram.sv */
// value slot memory, eight words per record, one write and one registered read
// standalone, no package use
module krs_slot_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned Aw    = 9
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [Aw-1:0]     waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [Aw-1:0]     raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/keyed_record_store.sv */
// keyed record store: open-addressed header memory with linear probing, slot memory
// steps: a word taken in IDLE probes header places in PROBE, reads a written slot in SLOT
// on a read hit, and waits in DONE until the registered response output is free
// throughput: one word at a time; worst case ENTRIES probes, one per header place
// clear word and reset both run a pass over all ENTRIES places of the header memory
// rst_ni is asynchronous active low; the store is empty after the reset pass
module keyed_record_store #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  krs_req_if.sink   req_i,
  krs_rsp_if.source rsp_o
);

  localparam int unsigned Aw  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned Saw = Aw + krs_pkg::SlotBits;

  krs_pkg::state_e state_q, state_d;

  logic [Aw-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic          clr_reply_q, clr_reply_d;
  logic [1:0]    act_q;
  logic [31:0]   key_q, ctx_q, wval_q;
  logic [2:0]    slot_q;
  logic signed [31:0] rval_q, rval_d;
  logic          hit_q, hit_d, full_q, full_d;

  logic               ovalid_q;
  logic signed [31:0] oval_q;
  logic               ohit_q, ofull_q;

  logic                tag_we;
  logic [Aw-1:0]       tag_waddr, tag_raddr;
  krs_pkg::tag_entry_t tag_wdata, tag_rdata;
  logic                slot_we;
  logic [Saw-1:0]      slot_waddr, slot_raddr;
  logic [31:0]         slot_rdata;

  logic          accept, out_free, match, last_probe;
  logic [Aw-1:0] idx_next, hash_idx;

  function automatic logic [Aw-1:0] hash_fn(input logic [31:0] k, input logic [31:0] c);
    logic [31:0] h;
    logic [Aw-1:0] acc;
    logic [Aw:0] wide;
    h = k ^ {c[15:0], c[31:16]} ^ {k[7:0], k[31:8]};
    acc = '0;
    for (int i = 0; i < 32; i++) begin
      acc[i % Aw] = acc[i % Aw] ^ h[i];
    end
    wide = {1'b0, acc};
    if (wide >= (Aw+1)'(ENTRIES)) begin
      wide = wide - (Aw+1)'(ENTRIES);
    end
    return wide[Aw-1:0];
  endfunction

  krs_tag_ram #(.Entries(ENTRIES), .Aw(Aw)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  krs_slot_ram #(.Depth(ENTRIES * krs_pkg::Slots), .Aw(Saw)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (wval_q),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  assign req_i.ready = (state_q == krs_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !ovalid_q || rsp_o.ready;
  assign hash_idx    = hash_fn(req_i.key_tag, req_i.context_tag);
  assign idx_next    = (idx_q == Aw'(ENTRIES - 1)) ? '0 : idx_q + 1'b1;
  assign match       = tag_rdata.valid && (tag_rdata.key == key_q) && (tag_rdata.ctx == ctx_q);
  assign last_probe  = (cnt_q == Aw'(ENTRIES - 1));
  assign slot_waddr  = {idx_q, slot_q};
  assign slot_raddr  = {idx_q, slot_q};
  assign tag_raddr   = (state_q == krs_pkg::ST_IDLE) ? hash_idx : idx_next;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    clr_reply_d = clr_reply_q;
    rval_d      = rval_q;
    hit_d       = hit_q;
    full_d      = full_q;
    tag_we      = 1'b0;
    tag_waddr   = idx_q;
    tag_wdata   = tag_rdata;
    slot_we     = 1'b0;
    case (state_q)
      krs_pkg::ST_CLR: begin
        tag_we    = 1'b1;
        tag_waddr = cnt_q;
        tag_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (last_probe) begin
          cnt_d   = '0;
          state_d = clr_reply_q ? krs_pkg::ST_DONE : krs_pkg::ST_IDLE;
        end
      end
      krs_pkg::ST_IDLE: begin
        if (accept) begin
          rval_d = '0;
          hit_d  = 1'b0;
          full_d = 1'b0;
          idx_d  = hash_idx;
          cnt_d  = '0;
          if (req_i.action == krs_pkg::ACT_WRITE || req_i.action == krs_pkg::ACT_READ) begin
            state_d = krs_pkg::ST_PROBE;
          end else if (req_i.action == krs_pkg::ACT_CLEAR) begin
            clr_reply_d = 1'b1;
            state_d     = krs_pkg::ST_CLR;
          end else begin
            state_d = krs_pkg::ST_DONE;
          end
        end
      end
      krs_pkg::ST_PROBE: begin
        if (match) begin
          hit_d = 1'b1;
          if (act_q == krs_pkg::ACT_WRITE) begin
            tag_we    = 1'b1;
            tag_wdata = tag_rdata;
            tag_wdata.written[slot_q] = 1'b1;
            slot_we   = 1'b1;
            state_d   = krs_pkg::ST_DONE;
          end else if (tag_rdata.written[slot_q]) begin
            state_d = krs_pkg::ST_SLOT;
          end else begin
            state_d = krs_pkg::ST_DONE;
          end
        end else if (!tag_rdata.valid) begin
          // free place ends the chain: the pair is absent
          if (act_q == krs_pkg::ACT_WRITE) begin
            tag_we    = 1'b1;
            tag_wdata.valid   = 1'b1;
            tag_wdata.key     = key_q;
            tag_wdata.ctx     = ctx_q;
            tag_wdata.written = '0;
            tag_wdata.written[slot_q] = 1'b1;
            slot_we   = 1'b1;
          end
          state_d = krs_pkg::ST_DONE;
        end else if (last_probe) begin
          full_d  = (act_q == krs_pkg::ACT_WRITE);
          state_d = krs_pkg::ST_DONE;
        end else begin
          idx_d = idx_next;
          cnt_d = cnt_q + 1'b1;
        end
      end
      krs_pkg::ST_SLOT: begin
        rval_d  = slot_rdata;
        state_d = krs_pkg::ST_DONE;
      end
      krs_pkg::ST_DONE: begin
        if (out_free) begin
          clr_reply_d = 1'b0;
          state_d     = krs_pkg::ST_IDLE;
        end
      end
      default: state_d = krs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= krs_pkg::ST_CLR;
      cnt_q       <= '0;
      idx_q       <= '0;
      clr_reply_q <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      clr_reply_q <= clr_reply_d;
      if (state_q == krs_pkg::ST_DONE && out_free) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rval_q <= rval_d;
    hit_q  <= hit_d;
    full_q <= full_d;
    if (accept) begin
      act_q  <= req_i.action;
      key_q  <= req_i.key_tag;
      ctx_q  <= req_i.context_tag;
      slot_q <= req_i.slot_select;
      wval_q <= req_i.write_value;
    end
    if (state_q == krs_pkg::ST_DONE && out_free) begin
      oval_q  <= rval_q;
      ohit_q  <= hit_q;
      ofull_q <= full_q;
    end
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.read_value = oval_q;
  assign rsp_o.hit        = ohit_q;
  assign rsp_o.store_full = ofull_q;

  a_full_not_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && rsp_o.store_full))
    else $error("refused write reported as hit");

  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == krs_pkg::ST_CLR) |-> !req_i.ready)
    else $error("word taken during clearing pass");

  a_one_write_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> (state_q == krs_pkg::ST_PROBE && act_q == krs_pkg::ACT_WRITE))
    else $error("slot write outside a write probe");

  a_done_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == krs_pkg::ST_DONE && out_free) |=> (rsp_o.valid && state_q == krs_pkg::ST_IDLE))
    else $error("result not presented after completion");

endmodule
